/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the press classifier checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define MBPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

/* hw/rtl/mbpc_pkg.sv */
// ----------------------------------------------------------------------------
// mbpc_pkg
// Types, codes and constants shared by the press classifier modules.
// ----------------------------------------------------------------------------
package mbpc_pkg;

	localparam int DEF_NUM_BUTTONS = 8;
	localparam int DEF_TIME_BITS   = 48;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam int BTN_IDX_W = 3;
	localparam int KIND_W    = 3;
	localparam int MS_W      = 32;
	localparam int MASK_W    = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 32;
	localparam int LIMIT_W   = 4;

	// Divider used for the microsecond to millisecond conversion.
	localparam int US_PER_MS  = 1000;
	localparam int REM_W      = $clog2(US_PER_MS);
	localparam int DIGIT_BITS = 8;
	localparam logic [REM_W:0] MS_DIVISOR = (REM_W + 1)'(US_PER_MS);

	localparam logic [LIMIT_W-1:0] EVT_LIMIT_CAP = LIMIT_W'(8);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_EXTRA_LONG = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_EVT_LIMIT  = CFG_IDX_W'(3);

	localparam logic [31:0] RST_DEBOUNCE   = 32'd20000;
	localparam logic [31:0] RST_LONG_PRESS = 32'd500000;
	localparam logic [31:0] RST_EXTRA_LONG = 32'd3000000;
	localparam logic [LIMIT_W-1:0] RST_EVT_LIMIT = LIMIT_W'(8);

	// Event codes.
	localparam logic [KIND_W-1:0] EV_SHORT   = KIND_W'(0);
	localparam logic [KIND_W-1:0] EV_LONG    = KIND_W'(1);
	localparam logic [KIND_W-1:0] EV_EXTRA   = KIND_W'(2);
	localparam logic [KIND_W-1:0] EV_HOLD    = KIND_W'(3);
	localparam logic [KIND_W-1:0] EV_RELEASE = KIND_W'(4);

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_DEBOUNCE = 5'b00010,
		PH_PRESSED  = 5'b00100,
		PH_LONG     = 5'b01000,
		PH_HOLD     = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [31:0]        debounce_time_us;
		logic [31:0]        long_press_time_us;
		logic [31:0]        extra_long_time_us;
		logic [LIMIT_W-1:0] events_per_scan_limit;
	} cfg_t;

	typedef struct packed {
		logic [BTN_IDX_W-1:0] button_index;
		logic [KIND_W-1:0]    event_kind;
		logic                 last_of_scan;
	} ev_info_t;

endpackage

/* hw/rtl/mbpc_queue.sv */
// ----------------------------------------------------------------------------
// mbpc_queue
// Short event queue between the button walker and the output divider.
// ----------------------------------------------------------------------------
module mbpc_queue #(
	parameter int TIME_BITS = mbpc_pkg::DEF_TIME_BITS,
	parameter int DEPTH     = mbpc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mbpc_pkg::ev_info_t     push_info,
	input  logic [TIME_BITS-1:0]   push_elapsed,
	output logic                   full,
	input  logic                   pop,
	output mbpc_pkg::ev_info_t     pop_info,
	output logic [TIME_BITS-1:0]   pop_elapsed,
	output logic                   empty
);
	import mbpc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ev_info_t             info_q [DEPTH];
	logic [TIME_BITS-1:0] elapsed_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_info    = info_q[rd_ptr_q];
	assign pop_elapsed = elapsed_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			info_q[wr_ptr_q]    <= push_info;
			elapsed_q[wr_ptr_q] <= push_elapsed;
		end
	end

endmodule

/* hw/rtl/mbpc_front.sv */
// ----------------------------------------------------------------------------
// mbpc_front
// Classifies each button of a scan, one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module mbpc_front #(
	parameter int NUM_BUTTONS = mbpc_pkg::DEF_NUM_BUTTONS,
	parameter int TIME_BITS   = mbpc_pkg::DEF_TIME_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbpc_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [TIME_BITS-1:0]          scan_time_us,
	input  logic [mbpc_pkg::MASK_W-1:0]   pressed_mask,
	input  logic                          q_full,
	output logic                          q_push,
	output mbpc_pkg::ev_info_t            q_info,
	output logic [TIME_BITS-1:0]          q_elapsed
);
	import mbpc_pkg::*;

	localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	typedef enum logic [2:0] {
		F_IDLE  = 3'b001,
		F_WALK  = 3'b010,
		F_FLUSH = 3'b100
	} front_state_t;

	front_state_t         state_q;
	logic [TIME_BITS-1:0] now_q;
	logic [MASK_W-1:0]    mask_q;
	logic [BTN_W-1:0]     btn_q;
	logic [LIMIT_W-1:0]   cnt_q;
	phase_t               phase_q [NUM_BUTTONS];
	logic [TIME_BITS-1:0] start_q [NUM_BUTTONS];
	logic                 xl_q [NUM_BUTTONS];
	logic                 pend_vld_q;
	ev_info_t             pend_info_q;
	logic [TIME_BITS-1:0] pend_el_q;

	phase_t               phase_rd;
	phase_t               phase_nx;
	logic [TIME_BITS-1:0] elapsed;
	logic                 pressed;
	logic                 ev_vld;
	logic [KIND_W-1:0]    ev_kind;
	logic                 set_start;
	logic                 set_xl;
	logic [LIMIT_W-1:0]   limit;
	logic                 emit;
	logic                 walk_push;
	logic                 advance;
	logic                 flush_push;
	logic                 flush_go;
	logic                 last_btn;

	assign in_stall = (state_q != F_IDLE);
	assign phase_rd = phase_q[btn_q];
	assign elapsed  = now_q - start_q[btn_q];
	assign limit    = (cfg.events_per_scan_limit > EVT_LIMIT_CAP) ? EVT_LIMIT_CAP
	                                                              : cfg.events_per_scan_limit;
	assign last_btn = (btn_q == BTN_W'(NUM_BUTTONS - 1));

	// Buttons past the mask width always read as released.
	always_comb begin
		pressed = 1'b0;
		for (int k = 0; k < MASK_W; k++) begin
			if (k < NUM_BUTTONS && int'(btn_q) == k) begin
				pressed = mask_q[k];
			end
		end
	end

	always_comb begin
		phase_nx  = phase_rd;
		ev_vld    = 1'b0;
		ev_kind   = EV_SHORT;
		set_start = 1'b0;
		set_xl    = 1'b0;
		case (phase_rd)
			PH_DEBOUNCE: begin
				if (!pressed) begin
					phase_nx = PH_IDLE;
				end else if (elapsed >= TIME_BITS'(cfg.debounce_time_us)) begin
					phase_nx = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (!pressed) begin
					phase_nx = PH_IDLE;
					ev_vld   = 1'b1;
					ev_kind  = EV_SHORT;
				end else if (elapsed >= TIME_BITS'(cfg.long_press_time_us)) begin
					phase_nx = PH_LONG;
					ev_vld   = 1'b1;
					ev_kind  = EV_LONG;
				end
			end
			PH_LONG: begin
				if (!pressed) begin
					phase_nx = PH_IDLE;
					ev_vld   = 1'b1;
					ev_kind  = EV_RELEASE;
				end else begin
					phase_nx = PH_HOLD;
				end
			end
			PH_HOLD: begin
				ev_vld = 1'b1;
				if (!pressed) begin
					phase_nx = PH_IDLE;
					ev_kind  = EV_RELEASE;
				end else if (!xl_q[btn_q] &&
				             elapsed >= TIME_BITS'(cfg.extra_long_time_us)) begin
					set_xl  = 1'b1;
					ev_kind = EV_EXTRA;
				end else begin
					ev_kind = EV_HOLD;
				end
			end
			default: begin
				if (pressed) begin
					phase_nx  = PH_DEBOUNCE;
					set_start = 1'b1;
				end else begin
					phase_nx = PH_IDLE;
				end
			end
		endcase
	end

	// An emitted event parks in the pending register; the one it replaces is
	// pushed, so only the flush knows which event closes the scan.
	assign emit       = ev_vld && (cnt_q < limit);
	assign walk_push  = (state_q == F_WALK) && emit && pend_vld_q;
	assign advance    = (state_q == F_WALK) && !(walk_push && q_full);
	assign flush_push = (state_q == F_FLUSH) && pend_vld_q;
	assign flush_go   = (state_q == F_FLUSH) && !(flush_push && q_full);
	assign q_push     = (walk_push || flush_push) && !q_full;

	always_comb begin
		q_info              = pend_info_q;
		q_info.last_of_scan = (state_q == F_FLUSH);
	end
	assign q_elapsed = pend_el_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			btn_q      <= '0;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				phase_q[b] <= PH_IDLE;
			end
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_WALK;
						btn_q   <= '0;
						cnt_q   <= '0;
					end
				end
				F_WALK: begin
					if (advance) begin
						phase_q[btn_q] <= phase_nx;
						if (emit) begin
							pend_vld_q <= 1'b1;
							cnt_q      <= cnt_q + 1'b1;
						end
						if (last_btn) begin
							state_q <= F_FLUSH;
						end else begin
							btn_q <= btn_q + 1'b1;
						end
					end
				end
				F_FLUSH: begin
					if (flush_go) begin
						pend_vld_q <= 1'b0;
						state_q    <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			now_q  <= scan_time_us;
			mask_q <= pressed_mask;
		end
		if (advance) begin
			if (set_start) begin
				start_q[btn_q] <= now_q;
				xl_q[btn_q]    <= 1'b0;
			end else if (set_xl) begin
				xl_q[btn_q] <= 1'b1;
			end
			if (emit) begin
				pend_info_q.button_index <= BTN_IDX_W'(btn_q);
				pend_info_q.event_kind   <= ev_kind;
				pend_info_q.last_of_scan <= 1'b0;
				pend_el_q                <= elapsed;
			end
		end
	end

endmodule

/* hw/rtl/mbpc_back.sv */
// ----------------------------------------------------------------------------
// mbpc_back
// Converts each queued event's elapsed time to milliseconds and presents it.
// ----------------------------------------------------------------------------
module mbpc_back #(
	parameter int TIME_BITS = mbpc_pkg::DEF_TIME_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	output logic                            q_pop,
	input  mbpc_pkg::ev_info_t              q_info,
	input  logic [TIME_BITS-1:0]            q_elapsed,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mbpc_pkg::BTN_IDX_W-1:0]  button_index,
	output logic [mbpc_pkg::KIND_W-1:0]     event_kind,
	output logic [mbpc_pkg::MS_W-1:0]       held_ms,
	output logic                            last_of_scan
);
	import mbpc_pkg::*;

	localparam int DIV_STEPS = (TIME_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int DIV_BITS  = DIV_STEPS * DIGIT_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	logic                  div_act_q;
	logic [CNT_W-1:0]      div_cnt_q;
	logic [DIV_BITS-1:0]   dvd_q;
	logic [DIV_BITS-1:0]   quo_q;
	logic [REM_W-1:0]      rem_q;
	ev_info_t              info_q;
	logic                  out_vld_q;
	ev_info_t              out_info_q;
	logic [MS_W-1:0]       out_ms_q;

	logic [REM_W-1:0]      rem_nx;
	logic [DIGIT_BITS-1:0] digit;
	logic                  div_done;
	logic                  move;

	// One quotient digit per cycle by restoring long division.
	always_comb begin
		logic [REM_W:0] trial;
		rem_nx = rem_q;
		digit  = '0;
		for (int k = DIGIT_BITS - 1; k >= 0; k--) begin
			trial = {rem_nx, dvd_q[DIV_BITS - DIGIT_BITS + k]};
			if (trial >= MS_DIVISOR) begin
				trial    = trial - MS_DIVISOR;
				digit[k] = 1'b1;
			end
			rem_nx = trial[REM_W-1:0];
		end
	end

	assign div_done = div_act_q && (div_cnt_q == CNT_W'(DIV_STEPS));
	assign move     = div_done && (!out_vld_q || !out_stall);
	assign q_pop    = !div_act_q && !q_empty;

	assign out_valid    = out_vld_q;
	assign button_index = out_info_q.button_index;
	assign event_kind   = out_info_q.event_kind;
	assign last_of_scan = out_info_q.last_of_scan;
	assign held_ms      = out_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_act_q <= 1'b0;
			div_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_pop) begin
				div_act_q <= 1'b1;
				div_cnt_q <= '0;
			end else if (move) begin
				div_act_q <= 1'b0;
			end else if (div_act_q && !div_done) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dvd_q  <= DIV_BITS'(q_elapsed);
			quo_q  <= '0;
			rem_q  <= '0;
			info_q <= q_info;
		end else if (div_act_q && !div_done) begin
			dvd_q <= dvd_q << DIGIT_BITS;
			quo_q <= {quo_q[DIV_BITS-DIGIT_BITS-1:0], digit};
			rem_q <= rem_nx;
		end
		if (move) begin
			out_info_q <= info_q;
			out_ms_q   <= quo_q[MS_W-1:0];
		end
	end

endmodule

/* hw/rtl/multi_button_press_classifier.sv */
// ----------------------------------------------------------------------------
// multi_button_press_classifier
// Per-button debounce, short, long, extra-long, hold and release detection.
// ----------------------------------------------------------------------------
// Each accepted scan (timestamp plus pressed mask) is walked one button per
// cycle: the classifier takes the scan, visits the buttons in index order
// and then closes the scan by marking its final event. Events go through a
// short queue to a millisecond converter that produces eight quotient
// bits per cycle and takes a new event only after the last one has left
// for the output register. The walker stalls only when the queue is full,
// and a new scan is taken while earlier events are still being converted
// or wait at the output. The per-button phase registers are cleared by
// reset; no clearing pass is needed and a scan can be taken once reset ends.
// ----------------------------------------------------------------------------
module multi_button_press_classifier #(
	parameter int NUM_BUTTONS = mbpc_pkg::DEF_NUM_BUTTONS,
	parameter int TIME_BITS   = mbpc_pkg::DEF_TIME_BITS,
	parameter int QUEUE_DEPTH = mbpc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mbpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbpc_pkg::CFG_DAT_W-1:0]   cfg_data,
	// Scan input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [TIME_BITS-1:0]             scan_time_us,
	input  logic [mbpc_pkg::MASK_W-1:0]      pressed_mask,
	// Event output channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mbpc_pkg::BTN_IDX_W-1:0]   button_index,
	output logic [mbpc_pkg::KIND_W-1:0]      event_kind,
	output logic [mbpc_pkg::MS_W-1:0]        held_ms,
	output logic                             last_of_scan
);
	import mbpc_pkg::*;

	cfg_t                 cfg_q;
	logic                 q_full;
	logic                 q_push;
	ev_info_t             q_push_info;
	logic [TIME_BITS-1:0] q_push_elapsed;
	logic                 q_empty;
	logic                 q_pop;
	ev_info_t             q_pop_info;
	logic [TIME_BITS-1:0] q_pop_elapsed;

	// Register writes are always taken. Writes to an unknown index are
	// acknowledged and dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time_us      <= RST_DEBOUNCE;
			cfg_q.long_press_time_us    <= RST_LONG_PRESS;
			cfg_q.extra_long_time_us    <= RST_EXTRA_LONG;
			cfg_q.events_per_scan_limit <= RST_EVT_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_time_us   <= cfg_data;
				REG_LONG_PRESS: cfg_q.long_press_time_us <= cfg_data;
				REG_EXTRA_LONG: cfg_q.extra_long_time_us <= cfg_data;
				REG_EVT_LIMIT:  cfg_q.events_per_scan_limit <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front walks buttons and decides which events are emitted.
	mbpc_front #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.TIME_BITS   (TIME_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.scan_time_us (scan_time_us),
		.pressed_mask (pressed_mask),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_info       (q_push_info),
		.q_elapsed    (q_push_elapsed)
	);

	// The queue lets the walker run ahead while the converter is busy.
	mbpc_queue #(
		.TIME_BITS (TIME_BITS),
		.DEPTH     (QUEUE_DEPTH)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (q_push),
		.push_info    (q_push_info),
		.push_elapsed (q_push_elapsed),
		.full         (q_full),
		.pop          (q_pop),
		.pop_info     (q_pop_info),
		.pop_elapsed  (q_pop_elapsed),
		.empty        (q_empty)
	);

	// The back converts the elapsed time to milliseconds and holds the
	// result in the output register until the transaction completes.
	mbpc_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_info       (q_pop_info),
		.q_elapsed    (q_pop_elapsed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.button_index (button_index),
		.event_kind   (event_kind),
		.held_ms      (held_ms),
		.last_of_scan (last_of_scan)
	);

endmodule

/* hw/rtl/mbpc_checker.sv */
// ----------------------------------------------------------------------------
// mbpc_checker
// Port-level checks for the press classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [mbpc_pkg::BTN_IDX_W-1:0]   button_index,
	input logic [mbpc_pkg::KIND_W-1:0]      event_kind,
	input logic [mbpc_pkg::MS_W-1:0]        held_ms,
	input logic                             last_of_scan
);
	import mbpc_pkg::*;

	// A stalled event transaction stays offered with the same payload.
	`MBPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(button_index) && $stable(event_kind) && $stable(held_ms) && $stable(last_of_scan))

	// A scan is walked button by button, so the next one waits.
	`MBPC_ASSERT_NEXT(a_scan_busy, clk, arst_n, in_valid && !in_stall, in_stall)

	// Only the five defined event codes leave the block.
	`MBPC_ASSERT_SAME(a_kind_code, clk, arst_n, out_valid, event_kind == EV_SHORT || event_kind == EV_LONG || event_kind == EV_EXTRA || event_kind == EV_HOLD || event_kind == EV_RELEASE)

endmodule

bind multi_button_press_classifier mbpc_checker u_mbpc_checker (.*);

/* bench/multi_button_press_classifier_test.sv */
// ----------------------------------------------------------------------------
// multi_button_press_classifier_test
// Self-checking bench for the eight-button press classifier.
// ----------------------------------------------------------------------------
// Scans are driven into the classifier. A scoreboard class runs its own copy
// of the per-button phase machines on every accepted scan and queues the
// events that scan must produce. Every event the classifier hands out is
// compared with the oldest queued one. The run walks through several register
// settings: reset values, short thresholds, all-zero thresholds, the largest
// thresholds, an event limit of zero, small limits that drop events, and
// limits above eight that must saturate. Sender gaps and receiver stalls
// change every few scans.
// ----------------------------------------------------------------------------
module multi_button_press_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mbpc_pkg::*;

	localparam int BUTTONS       = 8;
	localparam int TBITS         = 48;
	// Covers the walk of a scan that raises no event.
	localparam int SETTLE_CYCLES = 40;

	// One event as it leaves the classifier.
	typedef struct packed {
		logic [BTN_IDX_W-1:0] button;
		logic [KIND_W-1:0]    kind;
		logic [MS_W-1:0]      ms;
		logic                 last;
	} press_event_t;

	// Scoreboard: mirrors the classifier state and holds the events still due.
	class press_scoreboard;
		logic [31:0]        bounce_us;
		logic [31:0]        long_us;
		logic [31:0]        extra_us;
		logic [LIMIT_W-1:0] limit;
		phase_t             phase [BUTTONS];
		logic [TBITS-1:0]   start_us [BUTTONS];
		bit                 extra_seen [BUTTONS];
		press_event_t       pending_events [$];
		int                 failures;
		int                 scans;
		int                 checked;
		int                 kind_seen [5];

		function new();
			bounce_us = RST_DEBOUNCE;
			long_us = RST_LONG_PRESS;
			extra_us = RST_EXTRA_LONG;
			limit = RST_EVT_LIMIT;
			for (int i = 0; i < BUTTONS; i++) begin
				phase[i] = PH_IDLE;
				start_us[i] = '0;
				extra_seen[i] = 1'b0;
			end
			failures = 0;
			scans = 0;
			checked = 0;
			for (int k = 0; k < 5; k++)
				kind_seen[k] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_DEBOUNCE: bounce_us = data;
				REG_LONG_PRESS: long_us = data;
				REG_EXTRA_LONG: extra_us = data;
				REG_EVT_LIMIT: limit = data[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		// Advances every button by one scan and queues the events it raises.
		function void note_scan(logic [TBITS-1:0] now, logic [MASK_W-1:0] mask);
			logic [TBITS-1:0]   elapsed;
			logic [TBITS-1:0]   quot;
			logic [LIMIT_W-1:0] cap;
			logic [KIND_W-1:0]  kind;
			bit                 fire;
			int                 count;
			press_event_t       ev;
			cap = (limit > EVT_LIMIT_CAP) ? EVT_LIMIT_CAP : limit;
			count = 0;
			scans++;
			for (int i = 0; i < BUTTONS; i++) begin
				elapsed = now - start_us[i];
				fire = 1'b0;
				kind = EV_HOLD;
				case (phase[i])
					PH_DEBOUNCE: begin
						if (!mask[i])
							phase[i] = PH_IDLE;
						else if (elapsed >= {16'd0, bounce_us})
							phase[i] = PH_PRESSED;
					end
					PH_PRESSED: begin
						if (!mask[i]) begin
							phase[i] = PH_IDLE;
							fire = 1'b1;
							kind = EV_SHORT;
						end else if (elapsed >= {16'd0, long_us}) begin
							phase[i] = PH_LONG;
							fire = 1'b1;
							kind = EV_LONG;
						end
					end
					PH_LONG: begin
						fire = !mask[i];
						kind = EV_RELEASE;
						phase[i] = mask[i] ? PH_HOLD : PH_IDLE;
					end
					PH_HOLD: begin
						fire = 1'b1;
						if (!mask[i]) begin
							phase[i] = PH_IDLE;
							kind = EV_RELEASE;
						end else if (!extra_seen[i] && elapsed >= {16'd0, extra_us}) begin
							extra_seen[i] = 1'b1;
							kind = EV_EXTRA;
						end
					end
					default: begin
						if (mask[i]) begin
							phase[i] = PH_DEBOUNCE;
							start_us[i] = now;
							extra_seen[i] = 1'b0;
							elapsed = '0;
						end else begin
							phase[i] = PH_IDLE;
						end
					end
				endcase
				// Over the limit the event is dropped, but the state above still moved.
				if (fire && count < cap) begin
					quot = elapsed / TBITS'(US_PER_MS);
					ev.button = BTN_IDX_W'(i);
					ev.kind = kind;
					ev.ms = quot[MS_W-1:0];
					ev.last = 1'b0;
					pending_events.push_back(ev);
					count++;
				end
			end
			if (count > 0)
				pending_events[pending_events.size() - 1].last = 1'b1;
		endfunction

		function void check_event(press_event_t got);
			press_event_t want;
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event: button %0d kind %0d held_ms %0d last %0b",
					$time, got.button, got.kind, got.ms, got.last);
				failures++;
				return;
			end
			want = pending_events.pop_front();
			checked++;
			kind_seen[want.kind]++;
			if (got != want) begin
				$display("%0t: event mismatch: expected button %0d kind %0d held_ms %0d last %0b",
					$time, want.button, want.kind, want.ms, want.last);
				$display("%0t:                   actual button %0d kind %0d held_ms %0d last %0b",
					$time, got.button, got.kind, got.ms, got.last);
				failures++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [TBITS-1:0]     scan_time_us = '0;
	logic [MASK_W-1:0]    pressed_mask = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BTN_IDX_W-1:0] button_index;
	logic [KIND_W-1:0]    event_kind;
	logic [MS_W-1:0]      held_ms;
	logic                 last_of_scan;

	press_scoreboard      sb;

	// Stimulus state: the running timestamp and the mask the buttons hold.
	logic [TBITS-1:0]     now_us = 48'hFFFF_FFF0_BDC0;
	logic [MASK_W-1:0]    mask_state = '0;
	int                   n_sent = 0;
	int                   sender_idle_pct = 0;
	int                   stall_pct = 0;

	multi_button_press_classifier DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.scan_time_us(scan_time_us),
		.pressed_mask(pressed_mask),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.button_index(button_index),
		.event_kind  (event_kind),
		.held_ms     (held_ms),
		.last_of_scan(last_of_scan)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Event side: values are sampled as they stood before the edge, so a
	// transaction is counted when valid was high and our stall was low. The
	// stall for the next cycle is drawn afterwards.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_event({button_index, event_kind, held_ms, last_of_scan});
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Sends one scan. The idling pattern changes every fifteen scans and
	// cycles through: none, sender gaps, receiver stalls, and light gaps on
	// both sides. Valid is left high after the transaction, so a scan that
	// follows at once goes out back to back.
	task automatic send_scan(input logic [TBITS-1:0] t, input logic [MASK_W-1:0] m);
		case ((n_sent / 15) % 4)
			0: begin sender_idle_pct = 0;  stall_pct = 0;  end
			1: begin sender_idle_pct = 86; stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  stall_pct = 86; end
			default: begin sender_idle_pct = 16; stall_pct = 16; end
		endcase
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		scan_time_us <= t;
		pressed_mask <= m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_scan(t, m);
		n_sent++;
	endtask

	task automatic step(input logic [TBITS-1:0] dt, input logic [MASK_W-1:0] m);
		now_us = now_us + dt;
		send_scan(now_us, m);
	endtask

	// Drops valid, waits until every expected event has come out, then lets
	// the walker finish any scan that raised nothing.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Writes all four registers. A write to an unused index goes first; the
	// classifier must ignore it.
	task automatic program_regs(input logic [31:0] deb, input logic [31:0] lng,
		input logic [31:0] ext, input logic [LIMIT_W-1:0] lim);
		cfg_write(CFG_IDX_W'($urandom_range(4, 15)), $urandom);
		cfg_write(REG_DEBOUNCE, deb);
		cfg_write(REG_LONG_PRESS, lng);
		cfg_write(REG_EXTRA_LONG, ext);
		cfg_write(REG_EVT_LIMIT, CFG_DAT_W'(lim));
		cfg_valid <= 1'b0;
	endtask

	// Random scans. Mostly the held mask changes a few bits at a time with
	// time steps scaled to the thresholds, so buttons travel through every
	// phase. Some scans carry a random mask, and a few jump to a random
	// timestamp anywhere in the 48-bit range.
	task automatic run_random(input int count, input int unsigned step_max, input int jump_pct);
		logic [TBITS-1:0]  dt;
		logic [MASK_W-1:0] flips;
		for (int n = 0; n < count; n++) begin
			flips = MASK_W'($urandom & $urandom & $urandom);
			if ($urandom_range(0, 99) < 8)
				mask_state = MASK_W'($urandom);
			else
				mask_state = mask_state ^ flips;
			if ($urandom_range(0, 99) < jump_pct) begin
				now_us = {16'($urandom), 32'($urandom)};
				dt = '0;
			end else begin
				dt = TBITS'($urandom_range(0, step_max));
			end
			step(dt, mask_state);
		end
	endtask

	initial begin
		logic [31:0] deb;
		logic [31:0] lng;
		logic [31:0] ext;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset register values. The start time sits one
		// second below the wrap point, so the timestamp wraps mid-sequence.
		step(0, 8'h00);
		step(1000, 8'hFF);      // every button enters debounce
		step(10000, 8'hFF);     // still bouncing
		step(10000, 8'hFE);     // exactly at the debounce time; button 0 drops out
		step(100000, 8'hFC);    // button 1 lets go early: short press
		step(400000, 8'hFC);    // long press on buttons 2 to 7
		step(10000, 8'hF8);     // button 2 released from long; the rest go to hold
		step(10000, 8'hF8);     // hold events
		step(2500000, 8'hF0);   // time wraps; release on 3, extra long on 4 to 7
		step(1000, 8'hF0);      // extra long is reported only once
		step(1000, 8'hFF);      // buttons 0 to 3 start over
		step(30000, 8'hFF);
		step(500000, 8'hFF);    // eight events in one scan: four long, four hold
		step(1000, 8'hFF);
		step(1000, 8'hFF);      // eight hold events
		step(1000, 8'h00);      // eight releases
		mask_state = '0;
		run_random(30, 150000, 2);

		// Short thresholds so that buttons cycle through all phases quickly.
		settle();
		deb = $urandom_range(0, 300);
		lng = deb + $urandom_range(0, 600);
		ext = lng + $urandom_range(0, 1500);
		program_regs(deb, lng, ext, LIMIT_W'($urandom_range(1, 8)));
		run_random(60, 400, 2);

		// All thresholds zero and a limit of fifteen, which saturates at eight.
		settle();
		program_regs('0, '0, '0, LIMIT_W'(15));
		run_random(40, 60, 3);

		// Largest thresholds: only steps of billions of microseconds reach them.
		settle();
		program_regs('1, '1, '1, EVT_LIMIT_CAP);
		run_random(35, 32'h7FFF_FFFF, 5);

		// A limit of zero drops every event while the phases keep moving.
		settle();
		deb = $urandom_range(0, 200);
		program_regs(deb, deb + 300, deb + 900, '0);
		run_random(20, 300, 2);

		// Small limits, so busy scans lose their later events.
		settle();
		deb = $urandom_range(0, 200);
		program_regs(deb, deb + $urandom_range(0, 400), deb + $urandom_range(400, 1500),
			LIMIT_W'($urandom_range(1, 3)));
		run_random(60, 300, 2);

		// Mid-range thresholds with a limit between nine and fourteen.
		settle();
		program_regs(5000, 20000, 60000, LIMIT_W'($urandom_range(9, 14)));
		run_random(20, 8000, 2);

		settle();
		$display("Run covered %0d scans under seven register settings and checked %0d events.",
			sb.scans, sb.checked);
		$display("Events by kind: short %0d, long %0d, extra long %0d, hold %0d, release %0d.",
			sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3], sb.kind_seen[4]);
		if (sb.failures == 0)
			$display("[multi_button_press_classifier] OK");
		else
			$display("[multi_button_press_classifier] ERROR");
		$finish;
	end

	// Watchdog: a healthy run needs well under a tenth of this.
	initial begin
		#5_000_000;
		$display("Timeout: %0d events still expected.", sb.pending_events.size());
		$display("[multi_button_press_classifier] ERROR");
		$finish;
	end

endmodule
